// ===== rtl/eop_pkg.sv =====
// shared types, constants and register codes for the exposure outlier penalty block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package eop_pkg;

  localparam int MAX_IMAGES_DEFAULT = 16;
  localparam int RESULT_CAP         = 16;

  localparam int LUMA_W      = 20;
  localparam int LUMA_FRAC_W = 12;
  localparam int CUT_W       = 15;
  localparam int CUT_FRAC_W  = 16;
  localparam int HL_W        = 8;
  localparam int PEN_W       = 10;
  localparam int IDX_W       = 4;
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;

  // luma weights in q12
  localparam logic [10:0] LUMA_R_WT = 11'd1264;
  localparam logic [11:0] LUMA_G_WT = 12'd2496;
  localparam logic [8:0]  LUMA_B_WT = 9'd336;

  localparam logic [CUT_W-1:0] CUTOFF_RST    = 15'd22938;
  localparam logic [HL_W-1:0]  HIGHLIGHT_RST = 8'd100;
  localparam logic [PEN_W-1:0] PENALTY_RST   = 10'd384;

  typedef enum logic [1:0] {
    REG_CUTOFF    = 2'd0,
    REG_HIGHLIGHT = 2'd1,
    REG_PENALTY   = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_image;
  } sample_t;

  typedef struct packed {
    logic [PEN_W-1:0] penalty;
    logic [IDX_W-1:0] image_index;
    logic             last_result;
    logic             flat_pixel;
    logic             overflow;
  } result_t;

  typedef struct packed {
    logic [CUT_W-1:0] cutoff;
    logic [HL_W-1:0]  highlight;
    logic [PEN_W-1:0] penalty;
  } cfg_t;

  // controller to datapath commands
  typedef struct packed {
    logic mult_en;
    logic thresh_en;
    logic rd_en;
    logic rd_last;
  } dp_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/exposure_outlier_penalty.sv =====
// top level of the exposure outlier penalty block
// depends on eop_pkg, eop_regs, eop_ctrl and eop_datapath
`timescale 1ns / 1ps
`default_nettype none

// usage
// - input channel: a sample transaction (red, green, blue, last_image) is taken
//   at a rising edge with start high and busy low
// - samples of one pixel position arrive one per cycle, the last one marked;
//   up to MAX_IMAGES are stored, later ones are dropped and flag overflow
// - after the marked sample, busy stays high through ST_MULT for the range
//   times cutoff product, ST_THRESH for the low/high thresholds, then ST_EMIT
//   reading N samples from the store (N = stored samples, capped at 16)
// - results leave one per cycle on result_o with result_valid_o high for one
//   cycle each; the first strobe follows the product, threshold, store read
//   and result registers, the rest follow back to back in arrival order
// - the single read port of the sample store sets the one-result-per-cycle
//   drain rate
// - the receiver cannot stall: each result must be taken in its strobe cycle
// - the next run may start as soon as busy drops; the last two results are
//   still in flight then and do not depend on the new run
// - configuration: apb-style port, registers at byte addresses 0 (cutoff),
//   4 (highlight level), 8 (penalty); write only while the block is idle
// - reset clears the run state and loads the register defaults; the sample
//   store needs no clearing since only entries of the current run are read
module exposure_outlier_penalty import eop_pkg::*; #(
  parameter int MAX_IMAGES = MAX_IMAGES_DEFAULT
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // sample channel
  input  wire logic               start,
  output logic                    busy,
  input  wire sample_t            sample_i,
  // result channel
  output logic                    result_valid_o,
  output result_t                 result_o,
  // configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready
);

  localparam int AW = $clog2(MAX_IMAGES);
  localparam int CW = $clog2(MAX_IMAGES + 1);

  cfg_t          cfg;
  dp_cmd_t       cmd;
  logic [AW-1:0] rd_addr;
  logic [CW-1:0] count;
  logic          accept;

  // sample transaction accepted
  assign accept = start && !busy;

  eop_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // sequencing of threshold and read-out phases
  eop_ctrl #(
    .MAX_IMAGES (MAX_IMAGES)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .last_i    (sample_i.last_image),
    .count_i   (count),
    .cmd_o     (cmd),
    .rd_addr_o (rd_addr),
    .busy_o    (busy)
  );

  // luma, store, thresholds and result register
  eop_datapath #(
    .MAX_IMAGES (MAX_IMAGES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .sample_i       (sample_i),
    .cfg_i          (cfg),
    .cmd_i          (cmd),
    .rd_addr_i      (rd_addr),
    .count_o        (count),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

endmodule

`default_nettype wire

// ===== rtl/eop_regs.sv =====
// configuration register file behind the apb-style port
// depends on eop_pkg
`timescale 1ns / 1ps
`default_nettype none

module eop_regs import eop_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  output cfg_t                    cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[3:2])
        REG_CUTOFF:    cfg_d.cutoff    = pwdata[CUT_W-1:0];
        REG_HIGHLIGHT: cfg_d.highlight = pwdata[HL_W-1:0];
        REG_PENALTY:   cfg_d.penalty   = pwdata[PEN_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cutoff    <= CUTOFF_RST;
      cfg_q.highlight <= HIGHLIGHT_RST;
      cfg_q.penalty   <= PENALTY_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_CUTOFF:    prdata = PDATA_W'(cfg_q.cutoff);
      REG_HIGHLIGHT: prdata = PDATA_W'(cfg_q.highlight);
      REG_PENALTY:   prdata = PDATA_W'(cfg_q.penalty);
      default:       prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/eop_datapath.sv =====
// datapath: luma, sample store, min/max tracking, thresholds and result register
// depends on eop_pkg; driven by eop_ctrl commands
`timescale 1ns / 1ps
`default_nettype none

module eop_datapath import eop_pkg::*; #(
  parameter int MAX_IMAGES = MAX_IMAGES_DEFAULT
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              accept_i,
  input  wire sample_t                           sample_i,
  input  wire cfg_t                              cfg_i,
  input  wire dp_cmd_t                           cmd_i,
  input  wire logic [$clog2(MAX_IMAGES)-1:0]     rd_addr_i,
  output logic      [$clog2(MAX_IMAGES+1)-1:0]   count_o,
  output result_t                                result_o,
  output logic                                   result_valid_o
);

  localparam int AW     = $clog2(MAX_IMAGES);
  localparam int CW     = $clog2(MAX_IMAGES + 1);
  localparam int PROD_W = LUMA_W + CUT_W;

  logic [LUMA_W-1:0] store_mem [MAX_IMAGES];

  logic [LUMA_W-1:0] luma;
  logic [LUMA_W-1:0] min_q, max_q, range;
  logic [CW-1:0]     count_q;
  logic              dropped_q;
  logic              store_en;

  logic [PROD_W-1:0] prod_q;
  logic [LUMA_W-1:0] low_q, high_q;
  logic              flat_q, ovf_q;

  logic [LUMA_W-1:0] rdata_q;
  logic [AW-1:0]     p1_idx_q;
  logic              p1_valid_q, p1_last_q;

  logic [LUMA_W-1:0] bright;
  logic              hit;

  result_t result_q;
  logic    valid_q;

  assign luma = LUMA_W'(sample_i.red)   * LUMA_W'(LUMA_R_WT)
              + LUMA_W'(sample_i.green) * LUMA_W'(LUMA_G_WT)
              + LUMA_W'(sample_i.blue)  * LUMA_W'(LUMA_B_WT);

  assign store_en = accept_i && (count_q < CW'(MAX_IMAGES));
  assign range    = max_q - min_q;

  // run state: count, min, max, dropped flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q     <= '1;
      max_q     <= '0;
      count_q   <= '0;
      dropped_q <= 1'b0;
    end else if (cmd_i.rd_en && cmd_i.rd_last) begin
      min_q     <= '1;
      max_q     <= '0;
      count_q   <= '0;
      dropped_q <= 1'b0;
    end else if (accept_i) begin
      if (store_en) begin
        count_q <= count_q + CW'(1);
        if (luma < min_q) min_q <= luma;
        if (luma > max_q) max_q <= luma;
      end else begin
        dropped_q <= 1'b1;
      end
    end
  end

  // sample store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (store_en) begin
      store_mem[count_q[AW-1:0]] <= luma;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= store_mem[rd_addr_i];
    end
  end

  // trim amount, thresholds and read-stage index and last flag
  always_ff @(posedge clk_i) begin
    if (cmd_i.mult_en) begin
      prod_q <= PROD_W'(range) * PROD_W'(cfg_i.cutoff);
    end
    if (cmd_i.thresh_en) begin
      low_q  <= min_q + LUMA_W'(prod_q[PROD_W-1:CUT_FRAC_W]);
      high_q <= max_q - LUMA_W'(prod_q[PROD_W-1:CUT_FRAC_W]);
      flat_q <= (max_q == min_q);
      ovf_q  <= dropped_q;
    end
    if (cmd_i.rd_en) begin
      p1_idx_q  <= rd_addr_i;
      p1_last_q <= cmd_i.rd_last;
    end
  end

  assign bright = LUMA_W'({cfg_i.highlight, {LUMA_FRAC_W{1'b0}}});
  assign hit    = (rdata_q <= low_q) || ((rdata_q >= bright) && (rdata_q >= high_q));

  always_ff @(posedge clk_i) begin
    if (p1_valid_q) begin
      result_q.penalty     <= hit ? cfg_i.penalty : '0;
      result_q.image_index <= IDX_W'(p1_idx_q);
      result_q.last_result <= p1_last_q;
      result_q.flat_pixel  <= flat_q;
      result_q.overflow    <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      p1_valid_q <= cmd_i.rd_en;
      valid_q    <= p1_valid_q;
    end
  end

  assign count_o        = count_q;
  assign result_o       = result_q;
  assign result_valid_o = valid_q;

endmodule

`default_nettype wire

// ===== rtl/eop_ctrl.sv =====
// run controller: sequences threshold computation and the result read-out
// depends on eop_pkg; commands eop_datapath
`timescale 1ns / 1ps
`default_nettype none

module eop_ctrl import eop_pkg::*; #(
  parameter int MAX_IMAGES = MAX_IMAGES_DEFAULT
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              accept_i,
  input  wire logic                              last_i,
  input  wire logic [$clog2(MAX_IMAGES+1)-1:0]   count_i,
  output dp_cmd_t                                cmd_o,
  output logic      [$clog2(MAX_IMAGES)-1:0]     rd_addr_o,
  output logic                                   busy_o
);

  localparam int AW = $clog2(MAX_IMAGES);
  localparam int CW = $clog2(MAX_IMAGES + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MULT,
    ST_THRESH,
    ST_EMIT
  } state_e;

  state_e        state_q;
  dp_cmd_t       cmd_q;
  logic [AW-1:0] rd_addr_q;
  logic [CW-1:0] n_q;
  logic [CW-1:0] n_cap;
  logic          busy_q;

  // at most RESULT_CAP results per run
  always_comb begin
    if (32'(count_i) > RESULT_CAP) begin
      n_cap = CW'(RESULT_CAP);
    end else begin
      n_cap = count_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cmd_q     <= '0;
      rd_addr_q <= '0;
      n_q       <= '0;
      busy_q    <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept_i && last_i) begin
            state_q       <= ST_MULT;
            busy_q        <= 1'b1;
            cmd_q.mult_en <= 1'b1;
          end
        end
        ST_MULT: begin
          state_q         <= ST_THRESH;
          cmd_q.mult_en   <= 1'b0;
          cmd_q.thresh_en <= 1'b1;
        end
        ST_THRESH: begin
          state_q         <= ST_EMIT;
          cmd_q.thresh_en <= 1'b0;
          cmd_q.rd_en     <= 1'b1;
          cmd_q.rd_last   <= (n_cap == CW'(1));
          rd_addr_q       <= '0;
          n_q             <= n_cap;
        end
        ST_EMIT: begin
          if (cmd_q.rd_last) begin
            state_q       <= ST_IDLE;
            busy_q        <= 1'b0;
            cmd_q.rd_en   <= 1'b0;
            cmd_q.rd_last <= 1'b0;
          end else begin
            rd_addr_q     <= rd_addr_q + AW'(1);
            cmd_q.rd_last <= ((CW'(rd_addr_q) + CW'(2)) == n_q);
          end
        end
        default: begin
          state_q <= ST_IDLE;
          cmd_q   <= '0;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  assign cmd_o     = cmd_q;
  assign rd_addr_o = rd_addr_q;
  assign busy_o    = busy_q;

endmodule

`default_nettype wire

// ===== rtl/eop_checker.sv =====
// port-level checker for exposure_outlier_penalty, bound to the top level
// depends on eop_pkg
`timescale 1ns / 1ps
`default_nettype none

module eop_checker import eop_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start,
  input wire logic               busy,
  input wire sample_t            sample_i,
  input wire logic               result_valid_o,
  input wire result_t            result_o
);

  // a marked sample closes the run and starts the threshold phase
  a_last_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && sample_i.last_image |=> busy)
    else $error("busy not raised after last sample");

  // an unmarked sample keeps the block open for more
  a_plain_keeps_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && !sample_i.last_image |=> !busy)
    else $error("busy raised on a non-final sample");

  // results of a run come back to back with rising index and constant flags
  a_run_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last_result |=>
      result_valid_o
      && (result_o.image_index == 4'($past(result_o.image_index) + 4'd1))
      && $stable(result_o.flat_pixel) && $stable(result_o.overflow))
    else $error("result run broken");

  // a new run cannot produce a result right after a run ends
  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.last_result |=> !result_valid_o)
    else $error("result right after end of run");

endmodule

bind exposure_outlier_penalty eop_checker u_eop_checker (.*);

`default_nettype wire
